@@ design/sdsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdsc_pkg;

   localparam int VALUE_W = 20;
   localparam int POS_W = 3;
   localparam int SEL_W = 3;
   localparam int SEG_W = 8;
   localparam int DIGIT_W = 4;
   localparam int DEFAULT_DIGIT_COUNT = 6;
   localparam int QUEUE_DEPTH = 2;

   // Segment patterns for a common-anode display, active low.
   localparam logic [SEG_W-1:0] SEG_ZERO  = 8'hC0;
   localparam logic [SEG_W-1:0] SEG_ONE   = 8'hF9;
   localparam logic [SEG_W-1:0] SEG_TWO   = 8'hA4;
   localparam logic [SEG_W-1:0] SEG_THREE = 8'hB0;
   localparam logic [SEG_W-1:0] SEG_FOUR  = 8'h99;
   localparam logic [SEG_W-1:0] SEG_FIVE  = 8'h92;
   localparam logic [SEG_W-1:0] SEG_SIX   = 8'h82;
   localparam logic [SEG_W-1:0] SEG_SEVEN = 8'hF8;
   localparam logic [SEG_W-1:0] SEG_EIGHT = 8'h80;
   localparam logic [SEG_W-1:0] SEG_NINE  = 8'h90;

   typedef struct packed {
      logic                convert;
      logic [VALUE_W-1:0]  value;
      logic [POS_W-1:0]    position;
      logic                shown;
   } queue_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_EMIT
   } back_state_type;

   // Largest number that the given count of decimal digits can show.
   function automatic logic [63:0] max_shown(input int count);
      logic [63:0] lim;
      lim = 64'd1;
      for (int i = 0; i < count; i++) begin
         lim = lim * 64'd10;
      end
      return lim - 64'd1;
   endfunction

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0: pattern = SEG_ZERO;
         4'd1: pattern = SEG_ONE;
         4'd2: pattern = SEG_TWO;
         4'd3: pattern = SEG_THREE;
         4'd4: pattern = SEG_FOUR;
         4'd5: pattern = SEG_FIVE;
         4'd6: pattern = SEG_SIX;
         4'd7: pattern = SEG_SEVEN;
         4'd8: pattern = SEG_EIGHT;
         default: pattern = SEG_NINE;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

@@ design/sdsc_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sdsc_req_if import sdsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [POS_W-1:0]   position;

   modport source (output valid, output value, output position, input ready);
   modport sink (input valid, input value, input position, output ready);
endinterface

interface sdsc_rsp_if import sdsc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEL_W-1:0] digit_select;
   logic [SEG_W-1:0] segments;

   modport source (output valid, output digit_select, output segments, input ready);
   modport sink (input valid, input digit_select, input segments, output ready);
endinterface

`default_nettype wire

@@ design/sdsc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_front import sdsc_pkg::*; #(
   parameter int DIGIT_COUNT = DEFAULT_DIGIT_COUNT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   sdsc_req_if.sink             req_chan,
   output queue_entry_type      push_entry,
   output logic                 push_valid,
   input  wire logic            push_ready
);

   localparam logic [63:0] MAX_VALUE = max_shown(DIGIT_COUNT);

   logic [VALUE_W-1:0] last_value_ff;
   logic [VALUE_W-1:0] last_value_in;
   logic [VALUE_W-1:0] clamped;
   logic               accept;

   always_comb begin
      if ({{(64-VALUE_W){1'b0}}, req_chan.value} > MAX_VALUE) begin
         clamped = MAX_VALUE[VALUE_W-1:0];
      end else begin
         clamped = req_chan.value;
      end
   end

   assign accept = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;
   assign push_valid = req_chan.valid;

   always_comb begin
      push_entry.convert = (clamped != last_value_ff);
      push_entry.value = clamped;
      push_entry.position = req_chan.position;
      push_entry.shown = ({1'b0, req_chan.position} < (POS_W + 1)'(DIGIT_COUNT));
   end

   assign last_value_in = accept ? clamped : last_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_value_ff <= '0;
      end else begin
         last_value_ff <= last_value_in;
      end
   end

endmodule

`default_nettype wire

@@ design/sdsc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_queue import sdsc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire queue_entry_type  push_entry,
   output logic                  pop_valid,
   input  wire logic             pop,
   output queue_entry_type       head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign head = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ design/sdsc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_back import sdsc_pkg::*; #(
   parameter int DIGIT_COUNT = DEFAULT_DIGIT_COUNT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire queue_entry_type  head,
   output logic                  pop,
   sdsc_rsp_if.source            rsp_chan
);

   localparam int BCD_W = DIGIT_W * DIGIT_COUNT;
   localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int CNT_W = $clog2(VALUE_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

   back_state_type state_ff;
   back_state_type state_in;

   logic [DIGIT_W-1:0] store_ff [DIGIT_COUNT];
   logic [DIGIT_W-1:0] store_in [DIGIT_COUNT];
   logic [VALUE_W-1:0] shift_ff;
   logic [VALUE_W-1:0] shift_in;
   logic [BCD_W-1:0]   bcd_ff;
   logic [BCD_W-1:0]   bcd_in;
   logic [BCD_W-1:0]   bcd_adj;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic               shown_ff;
   logic               shown_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SEL_W-1:0]   select_ff;
   logic [SEL_W-1:0]   select_in;
   logic [SEG_W-1:0]   segments_ff;
   logic [SEG_W-1:0]   segments_in;

   logic               out_free;
   logic               start;
   logic               step;
   logic               emit;
   logic               last_step;
   logic [POS_W-1:0]   emit_pos;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign last_step = (count_ff == LAST_STEP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (head_valid && head.convert) begin
               state_in = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            if (last_step) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (!shown_ff || out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      start = 1'b0;
      step = 1'b0;
      emit = 1'b0;
      emit_pos = head.position;
      case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               if (head.convert) begin
                  pop = 1'b1;
                  start = 1'b1;
               end else if (!head.shown) begin
                  pop = 1'b1;
               end else if (out_free) begin
                  pop = 1'b1;
                  emit = 1'b1;
               end
            end
         end
         BACK_CONVERT: begin
            step = 1'b1;
         end
         BACK_EMIT: begin
            emit_pos = pos_ff;
            emit = shown_ff && out_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Shift-and-add-three conversion, one bit of the value per cycle.
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (bcd_ff[DIGIT_W*k +: DIGIT_W] >= 4'd5) begin
            bcd_adj[DIGIT_W*k +: DIGIT_W] = bcd_ff[DIGIT_W*k +: DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[DIGIT_W*k +: DIGIT_W] = bcd_ff[DIGIT_W*k +: DIGIT_W];
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in = bcd_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      shown_in = shown_ff;
      if (start) begin
         shift_in = head.value;
         bcd_in = '0;
         count_in = '0;
         pos_in = head.position;
         shown_in = head.shown;
      end else if (step) begin
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], shift_ff[VALUE_W-1]};
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      for (int s = 0; s < DIGIT_COUNT; s++) begin
         if (step && last_step) begin
            store_in[s] = bcd_in[DIGIT_W*(DIGIT_COUNT-1-s) +: DIGIT_W];
         end else begin
            store_in[s] = store_ff[s];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      select_in = select_ff;
      segments_in = segments_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         select_in = emit_pos;
         segments_in = seg_pattern(store_ff[emit_pos[IDX_W-1:0]]);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         for (int s = 0; s < DIGIT_COUNT; s++) begin
            store_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
         for (int s = 0; s < DIGIT_COUNT; s++) begin
            store_ff[s] <= store_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff <= bcd_in;
      pos_ff <= pos_in;
      shown_ff <= shown_in;
      select_ff <= select_in;
      segments_ff <= segments_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.digit_select = select_ff;
   assign rsp_chan.segments = segments_ff;

endmodule

`default_nettype wire

@@ design/seven_segment_decimal_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decimal scanner for a multiplexed common-anode seven-segment display.
// Each transaction on req_chan carries a binary value and the digit position
// being scanned; each transaction on rsp_chan carries the digit select code
// and the active-low segment pattern for that position. Positions at or above
// DIGIT_COUNT produce no response, and values beyond the display range are
// clamped to the largest number it can show.
// A transaction whose value matches the previous one is answered from the
// stored digits: one transaction per cycle while no conversion runs and the
// receiver takes responses, with the response registered after the queue.
// A new value runs a bit-serial binary-to-decimal conversion first.
// A two-entry queue separates the input side from the converter, and the
// response register lets a new transaction be accepted while a response waits.
// Reset clears the stored value and digits to zero and empties the queue.
// When the receiver stalls, the response holds, the queue fills and req_chan
// ready drops until room frees up.
module seven_segment_decimal_scanner import sdsc_pkg::*; #(
   parameter int DIGIT_COUNT = DEFAULT_DIGIT_COUNT
) (
   input wire logic   clock,
   input wire logic   reset,
   sdsc_req_if.sink   req_chan,
   sdsc_rsp_if.source rsp_chan
);

   queue_entry_type push_entry;
   queue_entry_type head;
   logic            push_valid;
   logic            push_ready;
   logic            head_valid;
   logic            pop;

   sdsc_front #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   sdsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop        (pop),
      .head       (head)
   );

   sdsc_back #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

@@ test/seven_segment_decimal_scanner_test.sv @@
`timescale 1ns / 1ps

module seven_segment_decimal_scanner_test;
   import sdsc_pkg::*;

   localparam int DIGITS = DEFAULT_DIGIT_COUNT;
   localparam logic [VALUE_W-1:0] DISPLAY_MAX = 20'd999999;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DIRECTED_ROWS = 23;

   typedef struct packed {
      logic [SEL_W-1:0] digit_select;
      logic [SEG_W-1:0] segments;
   } scan_result_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      logic               typed;
      logic [SEL_W-1:0]   digit_select;
      logic [SEG_W-1:0]   segments;
   } scan_row_type;

   // Rows marked typed carry an expected response that is plain from the value
   // and position; the others take their expected response from the predictor.
   localparam scan_row_type DIRECTED_SCANS [DIRECTED_ROWS] = '{
      '{20'd0,       3'd0, 1'b1, 3'd0, SEG_ZERO},
      '{20'd0,       3'd5, 1'b1, 3'd5, SEG_ZERO},
      '{20'd0,       3'd7, 1'b0, 3'd0, 8'h00},
      '{20'd999999,  3'd0, 1'b1, 3'd0, SEG_NINE},
      '{20'd999999,  3'd5, 1'b1, 3'd5, SEG_NINE},
      '{20'hFFFFF,   3'd3, 1'b1, 3'd3, SEG_NINE},
      '{20'd1000000, 3'd6, 1'b0, 3'd0, 8'h00},
      '{20'd123456,  3'd0, 1'b0, 3'd0, 8'h00},
      '{20'd123456,  3'd1, 1'b0, 3'd0, 8'h00},
      '{20'd123456,  3'd2, 1'b0, 3'd0, 8'h00},
      '{20'd123456,  3'd3, 1'b0, 3'd0, 8'h00},
      '{20'd123456,  3'd4, 1'b0, 3'd0, 8'h00},
      '{20'd123456,  3'd5, 1'b0, 3'd0, 8'h00},
      '{20'd987654,  3'd7, 1'b0, 3'd0, 8'h00},
      '{20'd987654,  3'd1, 1'b0, 3'd0, 8'h00},
      '{20'd1,       3'd5, 1'b1, 3'd5, SEG_ONE},
      '{20'd1,       3'd0, 1'b1, 3'd0, SEG_ZERO},
      '{20'd100000,  3'd0, 1'b1, 3'd0, SEG_ONE},
      '{20'd24680,   3'd2, 1'b0, 3'd0, 8'h00},
      '{20'd24680,   3'd4, 1'b0, 3'd0, 8'h00},
      '{20'd13579,   3'd1, 1'b0, 3'd0, 8'h00},
      '{20'd13579,   3'd3, 1'b0, 3'd0, 8'h00},
      '{20'd13579,   3'd5, 1'b0, 3'd0, 8'h00}
   };

   logic clock;
   logic reset;
   logic steady;
   int   mismatch_count;

   logic [VALUE_W-1:0] shown_value;
   logic [DIGIT_W-1:0] shown_digits [DIGITS];
   logic [SEG_W-1:0]   digit_patterns [10];
   scan_result_type    expected_scans [$];

   sdsc_req_if req_chan ();
   sdsc_rsp_if rsp_chan ();

   seven_segment_decimal_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Updates the stored value and digits and gives the response, if any.
   function automatic logic predict_scan(input logic [VALUE_W-1:0] value,
                                         input logic [POS_W-1:0] position,
                                         output scan_result_type result);
      logic [VALUE_W-1:0] clamped;
      logic [DIGIT_W-1:0] digit;
      clamped = (value > DISPLAY_MAX) ? DISPLAY_MAX : value;
      if (clamped != shown_value) begin
         shown_value = clamped;
         for (int k = DIGITS - 1; k >= 0; k--) begin
            shown_digits[k] = DIGIT_W'(clamped % 10);
            clamped = clamped / VALUE_W'(10);
         end
      end
      result = '0;
      if (position >= DIGITS) begin
         return 1'b0;
      end
      digit = (shown_digits[position] > 4'd9) ? 4'd9 : shown_digits[position];
      result.digit_select = position;
      result.segments = digit_patterns[digit];
      return 1'b1;
   endfunction

   task automatic send_scan(input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position,
                            input logic typed,
                            input scan_result_type typed_result);
      scan_result_type predicted;
      logic            has_result;
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= value;
      req_chan.position <= position;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      has_result = predict_scan(value, position, predicted);
      if (has_result) begin
         expected_scans.push_back(typed ? typed_result : predicted);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_scans.size() == 0) begin
            $error("unexpected response: digit_select %0d segments %h",
                   rsp_chan.digit_select, rsp_chan.segments);
            mismatch_count++;
         end else begin
            want = expected_scans.pop_front();
            if (rsp_chan.digit_select !== want.digit_select) begin
               $error("digit_select: expected %0d, actual %0d",
                      want.digit_select, rsp_chan.digit_select);
               mismatch_count++;
            end
            if (rsp_chan.segments !== want.segments) begin
               $error("segments: expected %h, actual %h", want.segments, rsp_chan.segments);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] last_sent;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   scan_position;
      scan_result_type    typed_result;

      digit_patterns = '{SEG_ZERO, SEG_ONE, SEG_TWO, SEG_THREE, SEG_FOUR,
                         SEG_FIVE, SEG_SIX, SEG_SEVEN, SEG_EIGHT, SEG_NINE};
      shown_value = '0;
      for (int k = 0; k < DIGITS; k++) begin
         shown_digits[k] = '0;
      end
      mismatch_count = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.position = '0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SCANS[i]) begin
         typed_result.digit_select = DIRECTED_SCANS[i].digit_select;
         typed_result.segments = DIRECTED_SCANS[i].segments;
         send_scan(DIRECTED_SCANS[i].value, DIRECTED_SCANS[i].position,
                   DIRECTED_SCANS[i].typed, typed_result);
      end

      // Mostly a display scan over the positions, with the value often held
      // so that the stored digits are reused between conversions.
      last_sent = DIRECTED_SCANS[DIRECTED_ROWS-1].value;
      scan_position = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 500 && n < 700);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: value = last_sent;
            4, 5, 6: value = VALUE_W'($urandom_range(0, 999999));
            7: value = VALUE_W'($urandom_range(999990, 20'hFFFFF));
            8: value = VALUE_W'($urandom());
            default: value = VALUE_W'($urandom_range(0, 99));
         endcase
         if ($urandom_range(0, 99) < 20) begin
            position = POS_W'($urandom_range(0, 7));
         end else begin
            position = scan_position;
            scan_position = scan_position + 3'd1;
         end
         last_sent = value;
         send_scan(value, position, 1'b0, '0);
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      while (expected_scans.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_scans.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/sdsc_pkg.sv
design/sdsc_ifs.sv
design/sdsc_front.sv
design/sdsc_queue.sv
design/sdsc_back.sv
design/seven_segment_decimal_scanner.sv
test/seven_segment_decimal_scanner_test.sv
